>>> hdl/sdc_pkg.sv
// Shared types, constants, latencies and binary32 helper functions for the spring constraint.
package sdc_pkg;

	typedef logic [31:0] fp32_t;
	typedef logic signed [10:0] fexp_t;

	localparam fp32_t QNAN_DEFAULT    = 32'hffc0_0000;
	localparam fp32_t QUIET_BIT       = 32'h0040_0000;
	localparam fp32_t MAGIC_RSQRT     = 32'h5f37_59df;
	localparam fp32_t FP_HALF         = 32'h3f00_0000;
	localparam fp32_t FP_THREE_HALVES = 32'h3fc0_0000;

	// unit latencies in cycles
	localparam int FADD_LAT   = 3;
	localparam int FMUL_LAT   = 3;
	localparam int FDIV_STEPS = 27;
	localparam int FDIV_LAT   = FDIV_STEPS + 2;

	// schedule: cycle at which each value sits in a unit's output register
	localparam int T_DXY  = FADD_LAT;
	localparam int T_SQ   = T_DXY + FMUL_LAT;
	localparam int T_SUM  = T_SQ + FADD_LAT;
	localparam int T_HALF = T_SUM + FMUL_LAT;
	localparam int T_T1   = T_HALF + FMUL_LAT;
	localparam int T_T2   = T_T1 + FMUL_LAT;
	localparam int T_T3   = T_T2 + FADD_LAT;
	localparam int T_INV  = T_T3 + FMUL_LAT;
	localparam int T_DIST = T_INV + FDIV_LAT;
	localparam int T_E1   = T_DIST + FADD_LAT;
	localparam int T_E2   = T_E1 + FMUL_LAT;
	localparam int T_ERR  = T_E2 + FMUL_LAT;
	localparam int T_OFS  = T_ERR + FMUL_LAT;
	localparam int T_OUT  = T_OFS + FADD_LAT;

	function automatic logic fp_is_nan(fp32_t x);
		return (x[30:23] == 8'hff) && (x[22:0] != 23'd0);
	endfunction

	function automatic logic fp_is_inf(fp32_t x);
		return (x[30:23] == 8'hff) && (x[22:0] == 23'd0);
	endfunction

	function automatic logic fp_is_zero(fp32_t x);
		return x[30:0] == 31'd0;
	endfunction

	function automatic fp32_t fp_quiet(fp32_t x);
		return x | QUIET_BIT;
	endfunction

	// significand with hidden bit
	function automatic logic [23:0] fp_mant(fp32_t x);
		return {x[30:23] != 8'd0, x[22:0]};
	endfunction

	// effective biased exponent, subnormals count as 1
	function automatic fexp_t fp_exp(fp32_t x);
		return (x[30:23] == 8'd0) ? fexp_t'(1) : fexp_t'({3'd0, x[30:23]});
	endfunction

	// leading zero count, 48 for an all-zero word
	function automatic logic [5:0] lzc48(logic [47:0] v);
		logic [5:0] n;
		n = 6'd48;
		for (int i = 0; i < 48; i++) begin
			if (v[i]) n = 6'(47 - i);
		end
		return n;
	endfunction

	// round to nearest even and pack; m[25] is the unit bit, m[1] guard, m[0] sticky
	function automatic fp32_t round_pack(logic s, fexp_t e, logic [25:0] m);
		fexp_t ee;
		fexp_t sh;
		logic [25:0] mm;
		logic [25:0] lost;
		logic [24:0] sig;
		logic inc;
		lost = 26'd0;
		sh = fexp_t'(0);
		if (e < fexp_t'(1)) begin
			// subnormal result: denormalize with sticky
			sh = fexp_t'(1) - e;
			if (sh > fexp_t'(25)) begin
				mm = {25'd0, |m};
			end else begin
				lost = m & ((26'd1 << sh[4:0]) - 26'd1);
				mm = (m >> sh[4:0]) | {25'd0, |lost};
			end
			ee = fexp_t'(1);
		end else begin
			mm = m;
			ee = e;
		end
		inc = mm[1] & (mm[0] | mm[2]);
		sig = {1'b0, mm[25:2]} + {24'd0, inc};
		if (sig[24]) begin
			sig = sig >> 1;
			ee = ee + fexp_t'(1);
		end
		if (ee > fexp_t'(254)) return {s, 8'hff, 23'd0};
		return {s, sig[23] ? ee[7:0] : 8'h00, sig[22:0]};
	endfunction

endpackage

>>> hdl/sdc_fmul.sv
// Three-stage binary32 multiplier: product, normalize, round.
module sdc_fmul (
	input  logic          clk,
	input  sdc_pkg::fp32_t a,
	input  sdc_pkg::fp32_t b,
	output sdc_pkg::fp32_t y
);

	logic           sgn_c;
	logic           spc_c;
	sdc_pkg::fp32_t spcv_c;

	logic           sgn_s1, spc_s1;
	sdc_pkg::fp32_t spcv_s1;
	sdc_pkg::fexp_t e_s1;
	logic [47:0]    p_s1;

	logic           sgn_s2, spc_s2;
	sdc_pkg::fp32_t spcv_s2;
	sdc_pkg::fexp_t e_s2;
	logic [47:0]    p_s2;
	logic [5:0]     z_c;

	// special operands
	always_comb begin
		sgn_c  = a[31] ^ b[31];
		spc_c  = 1'b1;
		spcv_c = {sgn_c, 31'd0};
		if (sdc_pkg::fp_is_nan(a)) begin
			spcv_c = sdc_pkg::fp_quiet(a);
		end else if (sdc_pkg::fp_is_nan(b)) begin
			spcv_c = sdc_pkg::fp_quiet(b);
		end else if ((sdc_pkg::fp_is_inf(a) && sdc_pkg::fp_is_zero(b)) ||
		             (sdc_pkg::fp_is_zero(a) && sdc_pkg::fp_is_inf(b))) begin
			spcv_c = sdc_pkg::QNAN_DEFAULT;
		end else if (sdc_pkg::fp_is_inf(a) || sdc_pkg::fp_is_inf(b)) begin
			spcv_c = {sgn_c, 8'hff, 23'd0};
		end else if (sdc_pkg::fp_is_zero(a) || sdc_pkg::fp_is_zero(b)) begin
			spcv_c = {sgn_c, 31'd0};
		end else begin
			spc_c = 1'b0;
		end
	end

	// stage 1: significand product
	always_ff @(posedge clk) begin
		sgn_s1  <= sgn_c;
		spc_s1  <= spc_c;
		spcv_s1 <= spcv_c;
		e_s1    <= sdc_pkg::fp_exp(a) + sdc_pkg::fp_exp(b) - sdc_pkg::fexp_t'(126);
		p_s1    <= sdc_pkg::fp_mant(a) * sdc_pkg::fp_mant(b);
	end

	// stage 2: normalize
	assign z_c = sdc_pkg::lzc48(p_s1);

	always_ff @(posedge clk) begin
		sgn_s2  <= sgn_s1;
		spc_s2  <= spc_s1;
		spcv_s2 <= spcv_s1;
		p_s2    <= p_s1 << z_c;
		e_s2    <= e_s1 - sdc_pkg::fexp_t'({5'd0, z_c});
	end

	// stage 3: round
	always_ff @(posedge clk) begin
		y <= spc_s2 ? spcv_s2 :
			sdc_pkg::round_pack(sgn_s2, e_s2, {p_s2[47:23], |p_s2[22:0]});
	end

endmodule

>>> hdl/sdc_fadd.sv
// Three-stage binary32 adder/subtractor: align, add, normalize and round.
module sdc_fadd (
	input  logic          clk,
	input  sdc_pkg::fp32_t a,
	input  sdc_pkg::fp32_t b,
	input  logic          sub,
	output sdc_pkg::fp32_t y
);

	sdc_pkg::fp32_t bb_c, big_c, lit_c, spcv_c;
	logic           swap_c, spc_c;
	sdc_pkg::fexp_t d_c;
	logic [26:0]    xsf_c, xs_c, lost_c;

	logic           spc_s1, sgn_s1, effsub_s1, zsgn_s1;
	sdc_pkg::fp32_t spcv_s1;
	sdc_pkg::fexp_t e_s1;
	logic [26:0]    xl_s1, xs_s1;

	logic [27:0]    r_c;
	logic [5:0]     z_c;
	sdc_pkg::fexp_t lim_c;

	logic           spc_s2, sgn_s2, zsgn_s2;
	sdc_pkg::fp32_t spcv_s2;
	sdc_pkg::fexp_t e_s2, shl_s2;
	logic [27:0]    r_s2;

	logic [26:0]    rs_c;
	logic [25:0]    m_c;
	sdc_pkg::fexp_t e3_c;
	logic           s3_c;

	// operand swap, alignment shift with sticky, special operands
	always_comb begin
		bb_c   = {b[31] ^ sub, b[30:0]};
		swap_c = bb_c[30:0] > a[30:0];
		big_c  = swap_c ? bb_c : a;
		lit_c  = swap_c ? a : bb_c;
		d_c    = sdc_pkg::fp_exp(big_c) - sdc_pkg::fp_exp(lit_c);
		xsf_c  = {sdc_pkg::fp_mant(lit_c), 3'd0};
		lost_c = 27'd0;
		if (d_c > sdc_pkg::fexp_t'(26)) begin
			xs_c = {26'd0, |xsf_c};
		end else begin
			lost_c = xsf_c & ((27'd1 << d_c[4:0]) - 27'd1);
			xs_c   = (xsf_c >> d_c[4:0]) | {26'd0, |lost_c};
		end
		spc_c  = 1'b1;
		spcv_c = a;
		if (sdc_pkg::fp_is_nan(a)) begin
			spcv_c = sdc_pkg::fp_quiet(a);
		end else if (sdc_pkg::fp_is_nan(b)) begin
			spcv_c = sdc_pkg::fp_quiet(b);
		end else if (sdc_pkg::fp_is_inf(a) && sdc_pkg::fp_is_inf(bb_c) &&
		             (a[31] != bb_c[31])) begin
			spcv_c = sdc_pkg::QNAN_DEFAULT;
		end else if (sdc_pkg::fp_is_inf(a)) begin
			spcv_c = a;
		end else if (sdc_pkg::fp_is_inf(bb_c)) begin
			spcv_c = bb_c;
		end else begin
			spc_c = 1'b0;
		end
	end

	// stage 1
	always_ff @(posedge clk) begin
		spc_s1    <= spc_c;
		spcv_s1   <= spcv_c;
		sgn_s1    <= big_c[31];
		effsub_s1 <= a[31] ^ bb_c[31];
		zsgn_s1   <= a[31] & bb_c[31];
		e_s1      <= sdc_pkg::fp_exp(big_c);
		xl_s1     <= {sdc_pkg::fp_mant(big_c), 3'd0};
		xs_s1     <= xs_c;
	end

	// stage 2: magnitude add, leading zero count limited by the exponent
	always_comb begin
		r_c   = effsub_s1 ? ({1'b0, xl_s1} - {1'b0, xs_s1}) : ({1'b0, xl_s1} + {1'b0, xs_s1});
		z_c   = sdc_pkg::lzc48({r_c[26:0], 21'd0});
		lim_c = e_s1 - sdc_pkg::fexp_t'(1);
	end

	always_ff @(posedge clk) begin
		spc_s2  <= spc_s1;
		spcv_s2 <= spcv_s1;
		sgn_s2  <= sgn_s1;
		zsgn_s2 <= zsgn_s1;
		e_s2    <= e_s1;
		r_s2    <= r_c;
		shl_s2  <= (sdc_pkg::fexp_t'({5'd0, z_c}) > lim_c) ? lim_c :
			sdc_pkg::fexp_t'({5'd0, z_c});
	end

	// stage 3: normalize and round; exact zero takes the sign rule of RNE
	always_comb begin
		rs_c = r_s2[26:0] << shl_s2[5:0];
		if (r_s2[27]) begin
			m_c  = {r_s2[27:3], |r_s2[2:0]};
			e3_c = e_s2 + sdc_pkg::fexp_t'(1);
		end else begin
			m_c  = {rs_c[26:2], |rs_c[1:0]};
			e3_c = e_s2 - shl_s2;
		end
		s3_c = (r_s2 == 28'd0) ? zsgn_s2 : sgn_s2;
	end

	always_ff @(posedge clk) begin
		y <= spc_s2 ? spcv_s2 : sdc_pkg::round_pack(s3_c, e3_c, m_c);
	end

endmodule

>>> hdl/sdc_frecip.sv
// Pipelined binary32 reciprocal: prenormalize, one restoring quotient bit per stage, round.
module sdc_frecip (
	input  logic          clk,
	input  sdc_pkg::fp32_t x,
	output sdc_pkg::fp32_t y
);

	localparam int STEPS = sdc_pkg::FDIV_STEPS;

	logic [23:0]    m_c;
	logic [5:0]     z_c;
	logic           spc_c;
	sdc_pkg::fp32_t spcv_c;

	logic [24:0]    rem_s  [STEPS+1];
	logic [26:0]    quo_s  [STEPS+1];
	logic [23:0]    dvs_s  [STEPS+1];
	sdc_pkg::fexp_t exp_s  [STEPS+1];
	logic           sgn_s  [STEPS+1];
	logic           spc_s  [STEPS+1];
	sdc_pkg::fp32_t spcv_s [STEPS+1];

	logic           ge_c [STEPS];
	logic [24:0]    nr_c [STEPS];

	logic [26:0]    q_c;
	logic           nz_c;
	logic [25:0]    mf_c;
	sdc_pkg::fexp_t ef_c;

	// prenormalize divisor; special operands
	always_comb begin
		m_c    = sdc_pkg::fp_mant(x);
		z_c    = sdc_pkg::lzc48({m_c, 24'd0});
		spc_c  = 1'b1;
		spcv_c = {x[31], 31'd0};
		if (sdc_pkg::fp_is_nan(x)) begin
			spcv_c = sdc_pkg::fp_quiet(x);
		end else if (sdc_pkg::fp_is_inf(x)) begin
			spcv_c = {x[31], 31'd0};
		end else if (sdc_pkg::fp_is_zero(x)) begin
			spcv_c = {x[31], 8'hff, 23'd0};
		end else begin
			spc_c = 1'b0;
		end
	end

	// one quotient bit per step
	always_comb begin
		for (int k = 0; k < STEPS; k++) begin
			ge_c[k] = rem_s[k] >= {1'b0, dvs_s[k]};
			nr_c[k] = ge_c[k] ? (rem_s[k] - {1'b0, dvs_s[k]}) : rem_s[k];
		end
	end

	always_ff @(posedge clk) begin
		rem_s[0]  <= 25'h080_0000;
		quo_s[0]  <= 27'd0;
		dvs_s[0]  <= m_c << z_c;
		exp_s[0]  <= sdc_pkg::fp_exp(x) - sdc_pkg::fexp_t'({5'd0, z_c});
		sgn_s[0]  <= x[31];
		spc_s[0]  <= spc_c;
		spcv_s[0] <= spcv_c;
		for (int k = 0; k < STEPS; k++) begin
			rem_s[k+1]  <= {nr_c[k][23:0], 1'b0};
			quo_s[k+1]  <= {quo_s[k][25:0], ge_c[k]};
			dvs_s[k+1]  <= dvs_s[k];
			exp_s[k+1]  <= exp_s[k];
			sgn_s[k+1]  <= sgn_s[k];
			spc_s[k+1]  <= spc_s[k];
			spcv_s[k+1] <= spcv_s[k];
		end
	end

	// quotient lies in (1/2, 1]
	always_comb begin
		q_c  = quo_s[STEPS];
		nz_c = |rem_s[STEPS];
		if (q_c[26]) begin
			mf_c = {q_c[26:2], q_c[1] | q_c[0] | nz_c};
			ef_c = sdc_pkg::fexp_t'(254) - exp_s[STEPS];
		end else begin
			mf_c = {q_c[25:1], q_c[0] | nz_c};
			ef_c = sdc_pkg::fexp_t'(253) - exp_s[STEPS];
		end
	end

	always_ff @(posedge clk) begin
		y <= spc_s[STEPS] ? spcv_s[STEPS] : sdc_pkg::round_pack(sgn_s[STEPS], ef_c, mf_c);
	end

endmodule

>>> hdl/spring_distance_constraint.sv
// Top level: pipelined 2-D distance constraint relaxation in binary32.
//
// Usage:
//   Present a_x, a_y, b_x, b_y and rest_length with start high; the item is
//   taken at the rising edge where start is high and busy is low. busy is only
//   high while in reset and until the first clock edge after it, so a new item
//   can be transferred on every clock.
//   new_a_x, new_a_y, new_b_x and new_b_y appear with done high for exactly one
//   cycle, from the output registers of the endpoint adders, in the order taken.
//   The receiver has no way to hold results back, and none is needed: the
//   pipeline never stalls and sustains one item per cycle.
//   The path from input to output runs through the input register, the dependent
//   chain of adds and multiplies, and the reciprocal unit, which forms one
//   quotient bit per stage.
//   Reset (arst_n low) clears every valid bit, so items in flight are dropped
//   and no done strobe follows until new items are taken.
module spring_distance_constraint (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] a_x,
	input  logic [31:0] a_y,
	input  logic [31:0] b_x,
	input  logic [31:0] b_y,
	input  logic [31:0] rest_length,
	output logic        done,
	output logic [31:0] new_a_x,
	output logic [31:0] new_a_y,
	output logic [31:0] new_b_x,
	output logic [31:0] new_b_y
);

	localparam int EST_LEN = sdc_pkg::T_T3 - sdc_pkg::T_SUM;
	localparam int EST_T1  = sdc_pkg::T_HALF - sdc_pkg::T_SUM - 1;
	localparam int EST_T2  = sdc_pkg::T_T1 - sdc_pkg::T_SUM - 1;
	localparam int EST_INV = sdc_pkg::T_T3 - sdc_pkg::T_SUM - 1;
	localparam int LEN_LEN = sdc_pkg::T_DIST;
	localparam int INV_LEN = sdc_pkg::T_E1 - sdc_pkg::T_INV;
	localparam int DXY_LEN = sdc_pkg::T_ERR - sdc_pkg::T_DXY;
	localparam int POS_LEN = sdc_pkg::T_OFS;
	localparam int VLD_LEN = sdc_pkg::T_OUT + 1;

	logic           busy_q;
	logic           accept;
	logic           vld_s [VLD_LEN];

	sdc_pkg::fp32_t ax_s0, ay_s0, bx_s0, by_s0, len_s0;
	sdc_pkg::fp32_t dx, dy, sx, sy, sum, half, t1, t2, t3, inv, distance;
	sdc_pkg::fp32_t e1, e2, err, ox, oy, est_c;

	sdc_pkg::fp32_t est_q [EST_LEN];
	sdc_pkg::fp32_t len_q [LEN_LEN];
	sdc_pkg::fp32_t inv_q [INV_LEN];
	sdc_pkg::fp32_t dx_q  [DXY_LEN];
	sdc_pkg::fp32_t dy_q  [DXY_LEN];
	sdc_pkg::fp32_t ax_q  [POS_LEN];
	sdc_pkg::fp32_t ay_q  [POS_LEN];
	sdc_pkg::fp32_t bx_q  [POS_LEN];
	sdc_pkg::fp32_t by_q  [POS_LEN];

	// ready once out of reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
		end else begin
			busy_q <= 1'b0;
		end
	end

	assign busy   = busy_q;
	assign accept = start & ~busy_q;

	// valid bits follow each item down the pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < VLD_LEN; k++) vld_s[k] <= 1'b0;
		end else begin
			vld_s[0] <= accept;
			for (int k = 1; k < VLD_LEN; k++) vld_s[k] <= vld_s[k-1];
		end
	end

	assign done = vld_s[VLD_LEN-1];

	// input register
	always_ff @(posedge clk) begin
		ax_s0  <= a_x;
		ay_s0  <= a_y;
		bx_s0  <= b_x;
		by_s0  <= b_y;
		len_s0 <= rest_length;
	end

	// alignment delay lines
	always_ff @(posedge clk) begin
		est_q[0] <= est_c;
		for (int k = 1; k < EST_LEN; k++) est_q[k] <= est_q[k-1];
		len_q[0] <= len_s0;
		for (int k = 1; k < LEN_LEN; k++) len_q[k] <= len_q[k-1];
		inv_q[0] <= inv;
		for (int k = 1; k < INV_LEN; k++) inv_q[k] <= inv_q[k-1];
		dx_q[0] <= dx;
		dy_q[0] <= dy;
		for (int k = 1; k < DXY_LEN; k++) begin
			dx_q[k] <= dx_q[k-1];
			dy_q[k] <= dy_q[k-1];
		end
		ax_q[0] <= ax_s0;
		ay_q[0] <= ay_s0;
		bx_q[0] <= bx_s0;
		by_q[0] <= by_s0;
		for (int k = 1; k < POS_LEN; k++) begin
			ax_q[k] <= ax_q[k-1];
			ay_q[k] <= ay_q[k-1];
			bx_q[k] <= bx_q[k-1];
			by_q[k] <= by_q[k-1];
		end
	end

	// differences and squared distance
	sdc_fadd u_dx  (.clk, .a(bx_s0), .b(ax_s0), .sub(1'b1), .y(dx));
	sdc_fadd u_dy  (.clk, .a(by_s0), .b(ay_s0), .sub(1'b1), .y(dy));
	sdc_fmul u_sx  (.clk, .a(dx), .b(dx), .y(sx));
	sdc_fmul u_sy  (.clk, .a(dy), .b(dy), .y(sy));
	sdc_fadd u_sum (.clk, .a(sx), .b(sy), .sub(1'b0), .y(sum));

	// inverse square root: bit-trick estimate and one Newton step
	assign est_c = sdc_pkg::MAGIC_RSQRT - {1'b0, sum[31:1]};

	sdc_fmul u_half (.clk, .a(sum), .b(sdc_pkg::FP_HALF), .y(half));
	sdc_fmul u_t1   (.clk, .a(half), .b(est_q[EST_T1]), .y(t1));
	sdc_fmul u_t2   (.clk, .a(t1), .b(est_q[EST_T2]), .y(t2));
	sdc_fadd u_t3   (.clk, .a(sdc_pkg::FP_THREE_HALVES), .b(t2), .sub(1'b1), .y(t3));
	sdc_fmul u_inv  (.clk, .a(est_q[EST_INV]), .b(t3), .y(inv));

	// distance and correction factor
	sdc_frecip u_dist (.clk, .x(inv), .y(distance));
	sdc_fadd   u_e1   (.clk, .a(len_q[LEN_LEN-1]), .b(distance), .sub(1'b1), .y(e1));
	sdc_fmul   u_e2   (.clk, .a(e1), .b(inv_q[INV_LEN-1]), .y(e2));
	sdc_fmul   u_err  (.clk, .a(e2), .b(sdc_pkg::FP_HALF), .y(err));
	sdc_fmul   u_ox   (.clk, .a(dx_q[DXY_LEN-1]), .b(err), .y(ox));
	sdc_fmul   u_oy   (.clk, .a(dy_q[DXY_LEN-1]), .b(err), .y(oy));

	// endpoint updates drive the outputs from their final registers
	sdc_fadd u_nax (.clk, .a(ax_q[POS_LEN-1]), .b(ox), .sub(1'b1), .y(new_a_x));
	sdc_fadd u_nay (.clk, .a(ay_q[POS_LEN-1]), .b(oy), .sub(1'b1), .y(new_a_y));
	sdc_fadd u_nbx (.clk, .a(bx_q[POS_LEN-1]), .b(ox), .sub(1'b0), .y(new_b_x));
	sdc_fadd u_nby (.clk, .a(by_q[POS_LEN-1]), .b(oy), .sub(1'b0), .y(new_b_y));

endmodule

>>> hdl/sdc_checker.sv
// Port-level checks for the spring constraint block, bound to the top level.
module sdc_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done
);

	localparam int LATENCY = sdc_pkg::T_OUT + 1;

	// every transfer yields a matching done strobe
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LATENCY done)
		else $error("transfer without matching done strobe");

	// every done strobe was caused by a transfer
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("done strobe without a matching transfer");

	// once ready, the block stays ready until the next reset
	assert property (@(posedge clk) disable iff (!arst_n)
		!busy |=> !busy)
		else $error("busy rose outside reset");

endmodule

bind spring_distance_constraint sdc_checker u_sdc_checker (.*);

>>> test/spring_distance_constraint_tb.sv
// Testbench for spring_distance_constraint: directed table plus random transfers, checked against a binary32 predictor.
`timescale 1ns / 100ps

module spring_distance_constraint_tb;
	import sdc_pkg::*;

	localparam int N_RANDOM   = 1800;
	localparam int CYCLE_MAX  = 400000;
	localparam int DRAIN_WAIT = T_OUT + 20;
	localparam fp32_t SIGN_BIT = 32'h8000_0000;

	typedef struct packed {
		fp32_t ax;
		fp32_t ay;
		fp32_t bx;
		fp32_t by;
	} endpoints_t;

	typedef struct {
		fp32_t      ax, ay, bx, by, len;
		logic       typed;
		endpoints_t want;
	} spring_row_t;

	logic  clk, arst_n, start, busy, done;
	fp32_t a_x, a_y, b_x, b_y, rest_length;
	fp32_t new_a_x, new_a_y, new_b_x, new_b_y;

	endpoints_t corrected_q[$];
	int         errors;
	int         cycles;

	spring_distance_constraint dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.a_x(a_x), .a_y(a_y), .b_x(b_x), .b_y(b_y), .rest_length(rest_length),
		.done(done), .new_a_x(new_a_x), .new_a_y(new_a_y),
		.new_b_x(new_b_x), .new_b_y(new_b_y)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// binary32 arithmetic, round to nearest even
	function automatic logic is_nan(fp32_t x);
		return (x[30:23] == 8'hff) && (x[22:0] != 23'd0);
	endfunction

	function automatic logic is_inf(fp32_t x);
		return (x[30:23] == 8'hff) && (x[22:0] == 23'd0);
	endfunction

	// NaN operand: first operand wins, quieted
	function automatic fp32_t nan_pick(fp32_t a, fp32_t b);
		return is_nan(a) ? (a | QUIET_BIT) : (b | QUIET_BIT);
	endfunction

	// value = m * 2^e
	function automatic fp32_t pack_rne(logic s, int e, logic [127:0] m);
		int p, sh, ex;
		logic [127:0] q, rem, half;
		p = 0;
		for (int i = 0; i < 128; i++) if (m[i]) p = i;
		sh = p - 23;
		if (sh < -149 - e) sh = -149 - e;
		if (sh > 127) begin
			q = '0;
		end else if (sh > 0) begin
			q = m >> sh;
			rem = m & ((128'd1 << sh) - 128'd1);
			half = 128'd1 << (sh - 1);
			if (rem > half || (rem == half && q[0])) q = q + 128'd1;
		end else begin
			q = m << (-sh);
		end
		if (q[24]) begin
			q = q >> 1;
			sh++;
		end
		ex = e + sh + 150;
		if (q[23]) begin
			if (ex > 254) return {s, 8'hff, 23'd0};
			return {s, ex[7:0], q[22:0]};
		end
		return {s, 8'h00, q[22:0]};
	endfunction

	function automatic fp32_t f_addsub(fp32_t a, fp32_t b, logic negate);
		logic sa, sb, st, s;
		int ea, eb, et, d, er;
		logic [127:0] ma, mb, mt, big, sml, mag;
		if (is_nan(a) || is_nan(b)) return nan_pick(a, b);
		b = b ^ (negate ? SIGN_BIT : 32'd0);
		if (is_inf(a) && is_inf(b) && (a[31] != b[31])) return QNAN_DEFAULT;
		if (is_inf(a)) return a;
		if (is_inf(b)) return b;
		if (a[30:0] == 31'd0 && b[30:0] == 31'd0) return {a[31] & b[31], 31'd0};
		if (a[30:0] == 31'd0) return b;
		if (b[30:0] == 31'd0) return a;
		sa = a[31];
		sb = b[31];
		ma = {104'd0, a[30:23] != 8'd0, a[22:0]};
		mb = {104'd0, b[30:23] != 8'd0, b[22:0]};
		ea = (a[30:23] == 8'd0) ? 1 : int'(a[30:23]);
		eb = (b[30:23] == 8'd0) ? 1 : int'(b[30:23]);
		if (ea < eb) begin
			st = sa; sa = sb; sb = st;
			mt = ma; ma = mb; mb = mt;
			et = ea; ea = eb; eb = et;
		end
		d = ea - eb;
		// far-apart operands: the small one only matters as a sticky bit
		if (d > 60) begin
			big = ma << 60;
			sml = 128'd1;
			er = ea - 210;
		end else begin
			big = ma << d;
			sml = mb;
			er = eb - 150;
		end
		if (sa == sb) begin
			mag = big + sml;
			s = sa;
		end else if (big >= sml) begin
			mag = big - sml;
			s = sa;
		end else begin
			mag = sml - big;
			s = sb;
		end
		if (mag == '0) return 32'd0;
		return pack_rne(s, er, mag);
	endfunction

	function automatic fp32_t f_mul(fp32_t a, fp32_t b);
		logic s;
		int ea, eb;
		logic [127:0] ma, mb;
		if (is_nan(a) || is_nan(b)) return nan_pick(a, b);
		s = a[31] ^ b[31];
		if ((is_inf(a) && b[30:0] == 31'd0) || (is_inf(b) && a[30:0] == 31'd0))
			return QNAN_DEFAULT;
		if (is_inf(a) || is_inf(b)) return {s, 8'hff, 23'd0};
		if (a[30:0] == 31'd0 || b[30:0] == 31'd0) return {s, 31'd0};
		ma = {104'd0, a[30:23] != 8'd0, a[22:0]};
		mb = {104'd0, b[30:23] != 8'd0, b[22:0]};
		ea = (a[30:23] == 8'd0) ? 1 : int'(a[30:23]);
		eb = (b[30:23] == 8'd0) ? 1 : int'(b[30:23]);
		return pack_rne(s, ea + eb - 300, ma * mb);
	endfunction

	function automatic fp32_t f_div(fp32_t a, fp32_t b);
		logic s;
		int ea, eb;
		logic [127:0] ma, mb, q, r;
		if (is_nan(a) || is_nan(b)) return nan_pick(a, b);
		s = a[31] ^ b[31];
		if ((is_inf(a) && is_inf(b)) || (a[30:0] == 31'd0 && b[30:0] == 31'd0))
			return QNAN_DEFAULT;
		if (is_inf(a) || b[30:0] == 31'd0) return {s, 8'hff, 23'd0};
		if (is_inf(b) || a[30:0] == 31'd0) return {s, 31'd0};
		ma = {104'd0, a[30:23] != 8'd0, a[22:0]};
		mb = {104'd0, b[30:23] != 8'd0, b[22:0]};
		ea = (a[30:23] == 8'd0) ? 1 : int'(a[30:23]);
		eb = (b[30:23] == 8'd0) ? 1 : int'(b[30:23]);
		q = (ma << 80) / mb;
		r = (ma << 80) % mb;
		return pack_rne(s, ea - eb - 81, (q << 1) | {127'd0, r != '0});
	endfunction

	// one relaxation step of the spring
	function automatic endpoints_t relax_spring(fp32_t ax, fp32_t ay, fp32_t bx, fp32_t by,
			fp32_t len);
		fp32_t dx, dy, sum, half, y, t, inv, distance, err, ox, oy;
		endpoints_t r;
		dx = f_addsub(bx, ax, 1'b1);
		dy = f_addsub(by, ay, 1'b1);
		sum = f_addsub(f_mul(dx, dx), f_mul(dy, dy), 1'b0);
		// magic-constant estimate, logical shift, wrapping subtract
		half = f_mul(sum, FP_HALF);
		y = MAGIC_RSQRT - (sum >> 1);
		t = f_mul(f_mul(half, y), y);
		t = f_addsub(FP_THREE_HALVES, t, 1'b1);
		inv = f_mul(y, t);
		// a zero inverse yields a signed infinity, as the divider gives
		distance = f_div(32'h3f80_0000, inv);
		err = f_mul(f_mul(f_addsub(len, distance, 1'b1), inv), FP_HALF);
		ox = f_mul(dx, err);
		oy = f_mul(dy, err);
		r.ax = f_addsub(ax, ox, 1'b1);
		r.ay = f_addsub(ay, oy, 1'b1);
		r.bx = f_addsub(bx, ox, 1'b0);
		r.by = f_addsub(by, oy, 1'b0);
		return r;
	endfunction

	function automatic fp32_t rand_coord();
		logic [7:0] ex;
		ex = 8'($urandom_range(117, 137));
		return {1'($urandom), ex, 23'($urandom)};
	endfunction

	function automatic fp32_t rand_raw();
		case ($urandom_range(0, 5))
			0: return {1'($urandom), 8'h00, 23'($urandom)};
			1: return {1'($urandom), 8'hff, 23'($urandom_range(0, 3) == 0 ? 0 : $urandom)};
			2: return {1'($urandom), 8'($urandom_range(1, 40)), 23'($urandom)};
			3: return {1'($urandom), 8'($urandom_range(200, 254)), 23'($urandom)};
			default: return $urandom;
		endcase
	endfunction

	// record each accepted transfer
	always @(posedge clk) begin
		if (arst_n && start && !busy)
			corrected_q.push_back(relax_spring(a_x, a_y, b_x, b_y, rest_length));
	end

	// compare each result with the oldest prediction
	always @(posedge clk) begin
		endpoints_t w;
		if (arst_n && done) begin
			if (corrected_q.size() == 0) begin
				$display("%0t: unexpected result %h %h %h %h", $time,
					new_a_x, new_a_y, new_b_x, new_b_y);
				errors++;
			end else begin
				w = corrected_q.pop_front();
				if (new_a_x !== w.ax) begin
					$display("%0t: new_a_x exp %h got %h", $time, w.ax, new_a_x);
					errors++;
				end
				if (new_a_y !== w.ay) begin
					$display("%0t: new_a_y exp %h got %h", $time, w.ay, new_a_y);
					errors++;
				end
				if (new_b_x !== w.bx) begin
					$display("%0t: new_b_x exp %h got %h", $time, w.bx, new_b_x);
					errors++;
				end
				if (new_b_y !== w.by) begin
					$display("%0t: new_b_y exp %h got %h", $time, w.by, new_b_y);
					errors++;
				end
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_MAX) begin
			$display("spring_distance_constraint_tb failed");
			$finish;
		end
	end

	// present one transfer, hold until taken
	task automatic send_spring(fp32_t ax, fp32_t ay, fp32_t bx, fp32_t by, fp32_t len);
		int gap;
		gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		a_x <= ax;
		a_y <= ay;
		b_x <= bx;
		b_y <= by;
		rest_length <= len;
		forever begin
			@(posedge clk);
			if (!busy) break;
		end
	endtask

	spring_row_t rows[$];
	spring_row_t rw;
	endpoints_t  zeros;

	initial begin
		errors = 0;
		cycles = 0;
		arst_n = 1'b0;
		start = 1'b0;
		a_x = '0; a_y = '0; b_x = '0; b_y = '0; rest_length = '0;
		zeros = '0;

		// directed rows; only the trivial ones carry a typed answer
		rows.push_back('{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1, zeros});
		rows.push_back('{32'h7fc00000, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1,
			'{32'h7fc00000, 32'h7fc00000, 32'h7fc00000, 32'h7fc00000}});
		rows.push_back('{32'h0, 32'h0, 32'h3f800000, 32'h0, 32'h40000000, 1'b0, zeros});
		rows.push_back('{32'h3f800000, 32'h40000000, 32'h40400000, 32'h40800000,
			32'h3f800000, 1'b0, zeros});
		rows.push_back('{32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
			32'hffffffff, 1'b0, zeros});
		rows.push_back('{32'h7f800000, 32'h0, 32'h0, 32'h0, 32'h3f800000, 1'b0, zeros});
		rows.push_back('{32'h0, 32'hff800000, 32'h0, 32'h0, 32'h3f800000, 1'b0, zeros});
		rows.push_back('{32'h7f800000, 32'h0, 32'h7f800000, 32'h0, 32'h0, 1'b0, zeros});
		rows.push_back('{32'hff7fffff, 32'h0, 32'h7f7fffff, 32'h0, 32'h7f7fffff, 1'b0, zeros});
		rows.push_back('{32'h0, 32'h0, 32'h00000001, 32'h00000001, 32'h0, 1'b0, zeros});
		rows.push_back('{32'h00800000, 32'h0, 32'h00000000, 32'h007fffff, 32'h00000001,
			1'b0, zeros});
		rows.push_back('{32'h3f800000, 32'h3f800000, 32'h3f800000, 32'h3f800000,
			32'h40a00000, 1'b0, zeros});
		rows.push_back('{32'h0, 32'h0, 32'h5f000000, 32'h5f000000, 32'h3f800000, 1'b0, zeros});
		rows.push_back('{32'h0, 32'h0, 32'h1e000000, 32'h0, 32'h0, 1'b0, zeros});
		rows.push_back('{32'h0, 32'h0, 32'h7f800001, 32'h0, 32'h0, 1'b0, zeros});
		rows.push_back('{32'h0, 32'h0, 32'h0, 32'h0, 32'hffc00000, 1'b0, zeros});
		rows.push_back('{32'h80000000, 32'h80000000, 32'h0, 32'h0, 32'h80000000, 1'b0, zeros});
		rows.push_back('{32'hc2c80000, 32'h42c80000, 32'h42c80000, 32'hc2c80000,
			32'h3f000000, 1'b0, zeros});

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			rw = rows[i];
			if (rw.typed && rw.want != relax_spring(rw.ax, rw.ay, rw.bx, rw.by, rw.len)) begin
				$display("%0t: row %0d exp %h pred %h", $time, i, rw.want,
					relax_spring(rw.ax, rw.ay, rw.bx, rw.by, rw.len));
				errors++;
			end
			send_spring(rw.ax, rw.ay, rw.bx, rw.by, rw.len);
		end

		for (int n = 0; n < N_RANDOM; n++) begin
			// one pause that lets the pipeline drain completely
			if (n == N_RANDOM / 2) begin
				start <= 1'b0;
				while (corrected_q.size() != 0) @(posedge clk);
				@(posedge clk);
			end
			if ($urandom_range(0, 9) < 7)
				send_spring(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
					{1'b0, 8'($urandom_range(117, 135)), 23'($urandom)});
			else
				send_spring(rand_raw(), rand_raw(), rand_raw(), rand_raw(), rand_raw());
		end
		start <= 1'b0;

		while (corrected_q.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (errors == 0)
			$display("spring_distance_constraint_tb passed");
		else
			$display("spring_distance_constraint_tb failed");
		$finish;
	end

endmodule

>>> files.f
hdl/sdc_pkg.sv
hdl/sdc_fmul.sv
hdl/sdc_fadd.sv
hdl/sdc_frecip.sv
hdl/spring_distance_constraint.sv
hdl/sdc_checker.sv
test/spring_distance_constraint_tb.sv
